// ----- hdl/pps_pkg.sv -----
// Shared constants, types and helper functions of the pattern scorer.
package pps_pkg;

	localparam int MAX_POSITIONS = 32;
	localparam int POS_W = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
	localparam int ADDR_W = POS_W + 2;
	localparam int DEPTH = MAX_POSITIONS * 4;

	localparam int LEN_W = 6;
	localparam int CNT_W = 6;
	localparam int WEIGHT_W = 16;
	localparam int SCORE_W = 21;
	localparam int SYMBOL_W = 8;
	localparam int FIELD_POS_W = 5;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	localparam logic ACTION_LOAD = 1'b0;
	localparam logic ACTION_CHAR = 1'b1;

	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_G = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;

	localparam logic [SYMBOL_W-1:0] CH_A_UP = 8'h41;
	localparam logic [SYMBOL_W-1:0] CH_A_LO = 8'h61;
	localparam logic [SYMBOL_W-1:0] CH_C_UP = 8'h43;
	localparam logic [SYMBOL_W-1:0] CH_C_LO = 8'h63;
	localparam logic [SYMBOL_W-1:0] CH_G_UP = 8'h47;
	localparam logic [SYMBOL_W-1:0] CH_G_LO = 8'h67;
	localparam logic [SYMBOL_W-1:0] CH_T_UP = 8'h54;
	localparam logic [SYMBOL_W-1:0] CH_T_LO = 8'h74;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_WALK,
		S_DRAIN,
		S_DONE
	} seq_state_t;

	typedef enum logic [1:0] {
		ACC_NOP,
		ACC_ADD,
		ACC_CLR,
		ACC_MIN
	} acc_op_t;

	typedef struct packed {
		acc_op_t op;
		logic    first;
		logic    fold;
	} acc_ctl_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} mem_ctl_t;

	typedef struct packed {
		logic load;
		logic too_short;
	} res_ctl_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] base;
	} base_code_t;

	function automatic base_code_t base_code(input logic [SYMBOL_W-1:0] ch);
		base_code_t r;
		r.hit = 1'b1;
		r.base = BASE_A;
		case (ch)
			CH_A_UP, CH_A_LO: r.base = BASE_A;
			CH_C_UP, CH_C_LO: r.base = BASE_C;
			CH_G_UP, CH_G_LO: r.base = BASE_G;
			CH_T_UP, CH_T_LO: r.base = BASE_T;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [LEN_W-1:0] used_len(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] r;
		r = (int'(len) > MAX_POSITIONS) ? LEN_W'(MAX_POSITIONS) : len;
		return r;
	endfunction

endpackage

// ----- hdl/pwm_pattern_scorer.sv -----
// Top level of the position weight matrix pattern scorer.
//
// Channel  Direction  Handshake         Content
// s_*      in         s_tvalid/s_tready weight load or pattern character
// m_*      out        m_tvalid/m_tready one score per finished pattern
// cfg_*    in         cfg_valid/cfg_ready motif length register
//
// A weight load is written in the idle state. A pattern character is read from the table
// and then added; when a final character ends a pattern shorter than the motif, the
// minimum score is walked through the single table read port before the result is given.
// Reset clears the sums, the character count and the motif length (to 1); the weight
// table holds no value until written. A result waits in the output register while the
// next items are taken; only the following result stalls until it has been taken.
module pwm_pattern_scorer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// position[4:0], base_index[6:5], weight[22:7], symbol[30:23], zero[31]
	input  logic [31:0]                 s_tdata,
	// action[0]
	input  logic                        s_tuser,
	input  logic                        s_tlast,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// score[20:0], zero[23:21]
	output logic [23:0]                 m_tdata,
	// too_short[0]
	output logic                        m_tuser,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [pps_pkg::LEN_W-1:0]   cfg_data
);
	import pps_pkg::*;

	logic [FIELD_POS_W-1:0]     position;
	logic [1:0]                 base_index;
	logic signed [WEIGHT_W-1:0] weight;
	logic [SYMBOL_W-1:0]        symbol;

	logic [LEN_W-1:0]           motif_len_q;
	logic                       out_vld_q;
	logic signed [SCORE_W-1:0]  score_q;
	logic                       too_short_q;
	logic                       out_free;

	mem_ctl_t                   mem;
	acc_ctl_t                   acc_ctl;
	res_ctl_t                   res;
	logic signed [WEIGHT_W-1:0] rd_data;
	logic signed [SCORE_W-1:0]  acc;

	assign position = s_tdata[4:0];
	assign base_index = s_tdata[6:5];
	assign weight = s_tdata[22:7];
	assign symbol = s_tdata[30:23];

	assign cfg_ready = 1'b1;
	assign out_free = !out_vld_q || m_tready;

	assign m_tvalid = out_vld_q;
	assign m_tdata = {3'b000, score_q};
	assign m_tuser = too_short_q;

	pps_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.action     (s_tuser),
		.position   (position),
		.base_index (base_index),
		.symbol     (symbol),
		.last       (s_tlast),
		.motif_len  (motif_len_q),
		.out_free   (out_free),
		.mem        (mem),
		.acc_ctl    (acc_ctl),
		.res        (res)
	);

	pps_wtab u_wtab (
		.clk     (clk),
		.mem     (mem),
		.wr_data (weight),
		.rd_data (rd_data)
	);

	pps_acc u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (acc_ctl),
		.rd_data (rd_data),
		.acc     (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motif_len_q <= LEN_W'(1);
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				motif_len_q <= cfg_data;
			end
			if (res.load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			score_q <= acc;
			too_short_q <= res.too_short;
		end
	end

endmodule

// ----- hdl/pps_wtab.sv -----
// Weight table memory with one write port and one registered read port.
module pps_wtab (
	input  logic                                clk,
	input  pps_pkg::mem_ctl_t                   mem,
	input  logic signed [pps_pkg::WEIGHT_W-1:0] wr_data,
	output logic signed [pps_pkg::WEIGHT_W-1:0] rd_data
);
	import pps_pkg::*;

	logic signed [WEIGHT_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (mem.wr_en) begin
			mem_q[mem.wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem.rd_en) begin
			rd_data <= mem_q[mem.rd_addr];
		end
	end

endmodule

// ----- hdl/pps_acc.sv -----
// Shared accumulate and minimum unit that builds the score.
module pps_acc (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pps_pkg::acc_ctl_t                   ctl,
	input  logic signed [pps_pkg::WEIGHT_W-1:0] rd_data,
	output logic signed [pps_pkg::SCORE_W-1:0]  acc
);
	import pps_pkg::*;

	logic signed [SCORE_W-1:0]  acc_q;
	logic signed [WEIGHT_W-1:0] lo_q;
	logic signed [WEIGHT_W-1:0] cand;

	assign cand = (ctl.first || (rd_data < lo_q)) ? rd_data : lo_q;
	assign acc = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			case (ctl.op)
				ACC_ADD: acc_q <= acc_q + SCORE_W'(rd_data);
				ACC_CLR: acc_q <= '0;
				ACC_MIN: begin
					if (ctl.fold) begin
						acc_q <= acc_q + SCORE_W'(cand);
					end
				end
				default: acc_q <= acc_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == ACC_MIN) begin
			lo_q <= cand;
		end
	end

endmodule

// ----- hdl/pps_seq.sv -----
// Sequencer that steps characters, table walks and result hand-off.
module pps_seq (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   action,
	input  logic [pps_pkg::FIELD_POS_W-1:0]        position,
	input  logic [1:0]                             base_index,
	input  logic [pps_pkg::SYMBOL_W-1:0]           symbol,
	input  logic                                   last,
	input  logic [pps_pkg::LEN_W-1:0]              motif_len,
	input  logic                                   out_free,
	output pps_pkg::mem_ctl_t                      mem,
	output pps_pkg::acc_ctl_t                      acc_ctl,
	output pps_pkg::res_ctl_t                      res
);
	import pps_pkg::*;

	seq_state_t        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              add_en_q;
	logic              last_q;
	logic [ADDR_W-1:0] walk_q;
	logic              walk_vld_s1;
	logic [1:0]        walk_base_s1;

	logic [LEN_W-1:0]  ulen;
	logic [ADDR_W-1:0] walk_end;
	base_code_t        code;
	logic              hit;
	logic              char_acc;
	logic              cnt_clr;
	logic              walk_start;
	logic              walk_step;

	assign ulen = used_len(motif_len);
	assign walk_end = {POS_W'(ulen - LEN_W'(1)), BASE_T};
	assign code = base_code(symbol);
	assign hit = code.hit && (cnt_q < ulen);

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		mem = '0;
		acc_ctl.op = walk_vld_s1 ? ACC_MIN : ACC_NOP;
		acc_ctl.first = (walk_base_s1 == BASE_A);
		acc_ctl.fold = (walk_base_s1 == BASE_T);
		res = '0;
		char_acc = 1'b0;
		cnt_clr = 1'b0;
		walk_start = 1'b0;
		walk_step = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (action == ACTION_LOAD) begin
						mem.wr_en = (int'(position) < MAX_POSITIONS);
						mem.wr_addr = {POS_W'(position), base_index};
					end else begin
						mem.rd_en = hit;
						mem.rd_addr = {POS_W'(cnt_q), code.base};
						char_acc = 1'b1;
						state_d = S_ADD;
					end
				end
			end
			S_ADD: begin
				if (!last_q) begin
					acc_ctl.op = add_en_q ? ACC_ADD : ACC_NOP;
					state_d = S_IDLE;
				end else if (cnt_q < ulen) begin
					acc_ctl.op = ACC_CLR;
					walk_start = 1'b1;
					state_d = S_WALK;
				end else begin
					acc_ctl.op = add_en_q ? ACC_ADD : ACC_NOP;
					state_d = S_DONE;
				end
			end
			S_WALK: begin
				mem.rd_en = 1'b1;
				mem.rd_addr = walk_q;
				walk_step = 1'b1;
				if (walk_q == walk_end) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					res.load = 1'b1;
					res.too_short = (cnt_q < ulen);
					acc_ctl.op = ACC_CLR;
					cnt_clr = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			add_en_q <= 1'b0;
			last_q <= 1'b0;
			walk_q <= '0;
			walk_vld_s1 <= 1'b0;
			walk_base_s1 <= BASE_A;
		end else begin
			state_q <= state_d;
			walk_vld_s1 <= (state_q == S_WALK);
			walk_base_s1 <= walk_q[1:0];
			if (char_acc) begin
				add_en_q <= hit;
				last_q <= last;
				if (cnt_q != COUNT_MAX) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end else if (cnt_clr) begin
				cnt_q <= '0;
			end
			if (walk_start) begin
				walk_q <= '0;
			end else if (walk_step) begin
				walk_q <= walk_q + ADDR_W'(1);
			end
		end
	end

endmodule
